### sv/invert_matrix_3x3_unit_defines.svh
// ---------------------------------------------------------------------------
// invert_matrix_3x3_unit defines
// assertion macros shared by the 3x3 inverse block
// ---------------------------------------------------------------------------
`ifndef INVERT_MATRIX_3X3_UNIT_DEFINES_SVH
`define INVERT_MATRIX_3X3_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define IM3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IM3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define IM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/im3_pkg.sv
// ---------------------------------------------------------------------------
// im3_pkg
// types and widths of the 3x3 matrix inverse block
// ---------------------------------------------------------------------------
package im3_pkg;

  localparam int ELEM_W    = 32;
  localparam int ADJ_MAG_W = 2 * ELEM_W;
  localparam int DET_W     = 3 * ELEM_W + 3;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic                     singular;
    logic                     saturated;
  } out_t;

endpackage

### sv/im3_div_lane.sv
// ---------------------------------------------------------------------------
// im3_div_lane
// pipelined restoring divider, one quotient bit per stage, with saturation
// ---------------------------------------------------------------------------
module im3_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [im3_pkg::ADJ_MAG_W-1:0]       num,
  input  logic [im3_pkg::DET_W-1:0]           den,
  input  logic                                neg,
  input  logic                                kill,
  output logic signed [im3_pkg::ELEM_W-1:0]   res,
  output logic                                sat,
  output logic                                kill_o
);

  localparam int W    = im3_pkg::ELEM_W;
  localparam int NSH  = im3_pkg::ADJ_MAG_W + 2 * FRAC_BITS;
  localparam int DSH  = im3_pkg::DET_W + W;
  localparam int CW   = (NSH > DSH) ? NSH : DSH;

  logic [CW-1:0]                r_r    [0:W-1];
  logic [im3_pkg::DET_W-1:0]    d_r    [0:W-1];
  logic [W-1:0]                 q_r    [0:W];
  logic                         big_r  [0:W];
  logic                         neg_r  [0:W];
  logic                         kill_r [0:W];

  logic [CW-1:0] num_sh;
  logic [CW-1:0] den_sh;

  always_comb begin
    num_sh = CW'(num) << (2 * FRAC_BITS);
    den_sh = CW'(den) << W;
  end

  // entry stage: quotient of 2^W or more saturates unless the item is killed
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= num_sh;
      d_r[0]    <= den;
      q_r[0]    <= '0;
      big_r[0]  <= (num_sh >= den_sh);
      neg_r[0]  <= neg;
      kill_r[0] <= kill;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_bit
    logic [CW-1:0] sub;
    logic          hit;

    always_comb begin
      sub = CW'(d_r[k-1]) << (W - k);
      hit = (r_r[k-1] >= sub);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= q_r[k-1] | (hit ? (W'(1) << (W - k)) : '0);
        big_r[k]  <= big_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        kill_r[k] <= kill_r[k-1];
      end
    end

    if (k < W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k] <= hit ? (r_r[k-1] - sub) : r_r[k-1];
          d_r[k] <= d_r[k-1];
        end
      end
    end
  end

  logic [W-1:0] lim;
  logic [W-1:0] mag;
  logic         sat_c;

  always_comb begin
    lim   = neg_r[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
    sat_c = big_r[W] || (q_r[W] > lim);
    mag   = sat_c ? lim : q_r[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res    <= kill_r[W] ? '0 : (neg_r[W] ? $signed(-mag) : $signed(mag));
      sat    <= sat_c && !kill_r[W];
      kill_o <= kill_r[W];
    end
  end

endmodule

### sv/invert_matrix_3x3_unit.sv
// ---------------------------------------------------------------------------
// invert_matrix_3x3_unit
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
// ---------------------------------------------------------------------------
// usage
//   in_valid/in_stall/in_data carry one whole matrix per transfer, nine
//   signed Q16.16 elements; out_valid/out_stall/out_data carry the inverse
//   plus singular and saturated flags, one result per matrix, in order
//   the path holds 5 + ELEM_W + 2 register stages (39 at 32-bit elements),
//   most of them in the one-bit-per-stage divider lanes
//   throughput: one matrix per cycle while out_stall is low; every stage,
//   the output register included, holds one item
//   when the receiver stalls a valid result, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated
//   reset clears all valid bits; payload registers are not reset
//   a zero determinant gives zero elements, singular set, saturated clear
// ---------------------------------------------------------------------------
`include "invert_matrix_3x3_unit_defines.svh"

module invert_matrix_3x3_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  im3_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output im3_pkg::out_t out_data
);

  localparam int W   = im3_pkg::ELEM_W;
  localparam int PW  = 2 * W;
  localparam int AW  = 2 * W + 1;
  localparam int DW  = im3_pkg::DET_W;
  localparam int NV  = 5 + W + 2;

  // adjugate terms: adj[i] = m[PA]*m[PB] - m[NA]*m[NB]
  localparam int PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int NA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int NB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic [NV-1:0] vld_r;
  logic          adv;

  // whole pipe moves unless a finished result is held by the receiver
  assign adv       = !(vld_r[NV-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  logic signed [W-1:0] m [0:8];
  always_comb begin
    m[0] = in_data.m00; m[1] = in_data.m01; m[2] = in_data.m02;
    m[3] = in_data.m10; m[4] = in_data.m11; m[5] = in_data.m12;
    m[6] = in_data.m20; m[7] = in_data.m21; m[8] = in_data.m22;
  end

  // stage 1: eighteen element products
  logic signed [PW-1:0] pp_r  [0:8];
  logic signed [PW-1:0] pn_r  [0:8];
  logic signed [W-1:0]  mt1_r [0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        pp_r[i] <= m[PA[i]] * m[PB[i]];
        pn_r[i] <= m[NA[i]] * m[NB[i]];
      end
      for (int j = 0; j < 3; j++) mt1_r[j] <= m[j];
    end
  end

  // stage 2: adjugate
  logic signed [AW-1:0] adj2_r [0:8];
  logic signed [W-1:0]  mt2_r  [0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) adj2_r[i] <= AW'(pp_r[i]) - AW'(pn_r[i]);
      for (int j = 0; j < 3; j++) mt2_r[j] <= mt1_r[j];
    end
  end

  // stage 3: det partial products, adjugate column split into low and high halves
  logic signed [AW-1:0] pl_r   [0:2];
  logic signed [AW-1:0] ph_r   [0:2];
  logic signed [AW-1:0] adj3_r [0:8];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        pl_r[j] <= mt2_r[j] * $signed({1'b0, adj2_r[3*j][W-1:0]});
        ph_r[j] <= mt2_r[j] * $signed(adj2_r[3*j][AW-1:W]);
      end
      for (int i = 0; i < 9; i++) adj3_r[i] <= adj2_r[i];
    end
  end

  // stage 4: determinant
  logic signed [DW-1:0] det_nxt;
  logic signed [DW-1:0] det_r;
  logic signed [AW-1:0] adj4_r [0:8];

  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DW'(ph_r[j]) <<< W) + DW'(pl_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r <= det_nxt;
      for (int i = 0; i < 9; i++) adj4_r[i] <= adj3_r[i];
    end
  end

  // stage 5: magnitudes and quotient signs
  logic signed [DW-1:0] det_neg;
  logic [DW-1:0]        dmag_r;
  logic                 zero_r;
  logic [PW-1:0]        amag_r [0:8];
  logic                 qneg_r [0:8];

  assign det_neg = -det_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag_r <= det_r[DW-1] ? det_neg : det_r;
      zero_r <= (det_r == '0);
      for (int i = 0; i < 9; i++) begin
        amag_r[i] <= adj4_r[i][AW-1] ? PW'(-adj4_r[i]) : PW'(adj4_r[i]);
        qneg_r[i] <= adj4_r[i][AW-1] ^ det_r[DW-1];
      end
    end
  end

  // divider lanes, output register is their last stage
  logic signed [W-1:0] res   [0:8];
  logic [8:0]          sat;
  logic [8:0]          kill_o;

  for (genvar i = 0; i < 9; i++) begin : g_lane
    im3_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (adv),
      .num    (amag_r[i]),
      .den    (dmag_r),
      .neg    (qneg_r[i]),
      .kill   (zero_r),
      .res    (res[i]),
      .sat    (sat[i]),
      .kill_o (kill_o[i])
    );
  end

  always_comb begin
    out_data.r00       = res[0];
    out_data.r01       = res[1];
    out_data.r02       = res[2];
    out_data.r10       = res[3];
    out_data.r11       = res[4];
    out_data.r12       = res[5];
    out_data.r20       = res[6];
    out_data.r21       = res[7];
    out_data.r22       = res[8];
    out_data.singular  = kill_o[0];
    out_data.saturated = |sat;
  end

  `IM3_ASSERT_NOW(a_sing_no_sat, clk, rst_n, out_valid && out_data.singular, !out_data.saturated, "saturated set on a singular result")
  `IM3_ASSERT_NOW(a_sing_zero, clk, rst_n, out_valid && out_data.singular, out_data.r00 == '0 && out_data.r11 == '0 && out_data.r22 == '0, "singular result with nonzero elements")
  `IM3_ASSERT_NEXT(a_enter, clk, rst_n, in_valid && !in_stall, vld_r[0], "transferred matrix missing from first stage")
  `IM3_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(vld_r), "pipeline moved under a stalled result")

endmodule

### tb/tb_invert_matrix_3x3_unit.sv
// ---------------------------------------------------------------------------
// tb_invert_matrix_3x3_unit
// self-checking bench for the 3x3 matrix inverse block: random and directed
// matrices go in under bursty traffic, each returned inverse is compared
// field by field with an exact wide-integer prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_invert_matrix_3x3_unit;

  localparam int FRAC      = 16;
  localparam int LATENCY   = 5 + im3_pkg::ELEM_W + 2;
  localparam int N_RANDOM  = 1200;

  typedef logic signed [255:0] wide_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  im3_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  im3_pkg::out_t out_data;

  im3_pkg::in_t  pending_mats[$];
  im3_pkg::out_t expected_inverses[$];
  int    n_errors = 0;
  int    n_checked = 0;
  int    n_singular = 0;
  int    n_saturated = 0;
  bit    stim_done = 1'b0;
  bit    hold_for_drain = 1'b0;

  // sender burst/gap shaping and receiver stall pattern
  int    burst_left = 0;
  int    gap_left = 0;
  int    stall_mode = 0;
  int    stall_phase = 0;

  always #2 clk = ~clk;

  invert_matrix_3x3_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // one inverse element: adj * 2^(2F) / det, truncated toward zero, clamped
  function automatic logic signed [im3_pkg::ELEM_W-1:0] quotient_elem(wide_t adj, wide_t det,
                                                                      inout bit sat);
    wide_t q;
    wide_t hi;
    wide_t lo;
    q  = (adj <<< (2 * FRAC)) / det;
    hi = (wide_t'(1) <<< (im3_pkg::ELEM_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (im3_pkg::ELEM_W - 1));
    if (q > hi) begin
      sat = 1'b1;
      q = hi;
    end else if (q < lo) begin
      sat = 1'b1;
      q = lo;
    end
    return q[im3_pkg::ELEM_W-1:0];
  endfunction

  // exact inverse by adjugate over determinant
  function automatic im3_pkg::out_t invert_matrix(im3_pkg::in_t a);
    wide_t m [9];
    wide_t adj [9];
    wide_t det;
    logic signed [im3_pkg::ELEM_W-1:0] r [9];
    im3_pkg::out_t res;
    bit sat;
    sat = 1'b0;
    m[0] = a.m00; m[1] = a.m01; m[2] = a.m02;
    m[3] = a.m10; m[4] = a.m11; m[5] = a.m12;
    m[6] = a.m20; m[7] = a.m21; m[8] = a.m22;
    adj[0] = m[4] * m[8] - m[5] * m[7];
    adj[1] = m[2] * m[7] - m[1] * m[8];
    adj[2] = m[1] * m[5] - m[2] * m[4];
    adj[3] = m[5] * m[6] - m[3] * m[8];
    adj[4] = m[0] * m[8] - m[2] * m[6];
    adj[5] = m[2] * m[3] - m[0] * m[5];
    adj[6] = m[3] * m[7] - m[4] * m[6];
    adj[7] = m[1] * m[6] - m[0] * m[7];
    adj[8] = m[0] * m[4] - m[1] * m[3];
    det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    for (int i = 0; i < 9; i++) r[i] = quotient_elem(adj[i], det, sat);
    res.r00 = r[0]; res.r01 = r[1]; res.r02 = r[2];
    res.r10 = r[3]; res.r11 = r[4]; res.r12 = r[5];
    res.r20 = r[6]; res.r21 = r[7]; res.r22 = r[8];
    res.saturated = sat;
    return res;
  endfunction

  // random element: half the time moderate Q16.16 values, else full range, zero or extremes
  function automatic logic signed [im3_pkg::ELEM_W-1:0] rand_elem();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3, 4: return $urandom();
      5: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
      6: return ($urandom_range(0, 1) ? 1 : -1) * ($urandom_range(1, 4) <<< FRAC);
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic im3_pkg::in_t rand_matrix();
    im3_pkg::in_t a;
    int shape;
    a.m00 = rand_elem(); a.m01 = rand_elem(); a.m02 = rand_elem();
    a.m10 = rand_elem(); a.m11 = rand_elem(); a.m12 = rand_elem();
    a.m20 = rand_elem(); a.m21 = rand_elem(); a.m22 = rand_elem();
    shape = $urandom_range(0, 19);
    // a few singular shapes: repeated row, zero column
    if (shape == 0) begin
      a.m20 = a.m00; a.m21 = a.m01; a.m22 = a.m02;
    end else if (shape == 1) begin
      a.m01 = '0; a.m11 = '0; a.m21 = '0;
    end
    return a;
  endfunction

  function automatic im3_pkg::in_t diag_matrix(logic signed [im3_pkg::ELEM_W-1:0] d0,
                                               logic signed [im3_pkg::ELEM_W-1:0] d1,
                                               logic signed [im3_pkg::ELEM_W-1:0] d2);
    im3_pkg::in_t a;
    a = '0;
    a.m00 = d0; a.m11 = d1; a.m22 = d2;
    return a;
  endfunction

  task automatic queue_matrix(im3_pkg::in_t a);
    pending_mats.push_back(a);
  endtask

  task automatic report_diff(string field, logic [im3_pkg::ELEM_W-1:0] want,
                             logic [im3_pkg::ELEM_W-1:0] got);
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    n_errors++;
  endtask

  // stimulus
  initial begin
    im3_pkg::in_t a;
    localparam logic signed [im3_pkg::ELEM_W-1:0] ONE = 32'sh0001_0000;
    // identity, scaled and negative identity
    queue_matrix(diag_matrix(ONE, ONE, ONE));
    queue_matrix(diag_matrix(2 * ONE, -ONE, ONE / 2));
    queue_matrix(diag_matrix(-ONE, -ONE, -ONE));
    // zero matrix: singular
    queue_matrix('0);
    // tiny diagonal: inverse overflows, saturated both signs
    queue_matrix(diag_matrix(32'sd1, -32'sd1, 32'sd1));
    // extremes of the field
    queue_matrix(diag_matrix(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    queue_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    queue_matrix(diag_matrix(32'sh8000_0000, 32'sh7fff_ffff, -32'sd1));
    a = '1;
    queue_matrix(a);
    a = '{default: 32'sh8000_0000};
    queue_matrix(a);
    a = '{default: 32'sh7fff_ffff};
    queue_matrix(a);
    // permutation and general invertible matrix
    a = '0; a.m01 = ONE; a.m12 = ONE; a.m20 = ONE;
    queue_matrix(a);
    a = '{m00: 2*ONE, m01: ONE, m02: 0, m10: ONE, m11: 3*ONE, m12: ONE,
          m20: 0, m21: ONE, m22: 4*ONE};
    queue_matrix(a);
    // alternating bit patterns
    a = '{default: 32'sh5555_5555};
    a.m00 = 32'shaaaa_aaaa; a.m11 = 32'shaaaa_aaaa; a.m22 = 32'sh1234_5678;
    queue_matrix(a);
    for (int i = 0; i < N_RANDOM; i++) queue_matrix(rand_matrix());
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: bursts with random gaps; once partway through it holds off until drained
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_inverses.push_back(invert_matrix(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (hold_for_drain && expected_inverses.size() == 0 &&
            !(in_valid && !in_stall)) begin
          hold_for_drain <= 1'b0;
        end
        if (pending_mats.size() == 600 && !hold_for_drain && in_valid && !in_stall) begin
          hold_for_drain <= 1'b1;
          in_valid <= 1'b0;
        end else if (hold_for_drain || pending_mats.size() == 0) begin
          in_valid <= 1'b0;
          if (pending_mats.size() == 0) stim_done <= 1'b1;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_mats.pop_front();
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern: none, periodic, or random, switched now and then
  always @(posedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= (stall_phase % 5) < 2;
        default: out_stall <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    im3_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inverses.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        n_errors++;
      end else begin
        want = expected_inverses.pop_front();
        n_checked++;
        if (want.singular) n_singular++;
        if (want.saturated) n_saturated++;
        if (out_data.r00 !== want.r00) report_diff("r00", want.r00, out_data.r00);
        if (out_data.r01 !== want.r01) report_diff("r01", want.r01, out_data.r01);
        if (out_data.r02 !== want.r02) report_diff("r02", want.r02, out_data.r02);
        if (out_data.r10 !== want.r10) report_diff("r10", want.r10, out_data.r10);
        if (out_data.r11 !== want.r11) report_diff("r11", want.r11, out_data.r11);
        if (out_data.r12 !== want.r12) report_diff("r12", want.r12, out_data.r12);
        if (out_data.r20 !== want.r20) report_diff("r20", want.r20, out_data.r20);
        if (out_data.r21 !== want.r21) report_diff("r21", want.r21, out_data.r21);
        if (out_data.r22 !== want.r22) report_diff("r22", want.r22, out_data.r22);
        if (out_data.singular !== want.singular)
          report_diff("singular", want.singular, out_data.singular);
        if (out_data.saturated !== want.saturated)
          report_diff("saturated", want.saturated, out_data.saturated);
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_inverses.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("checked %0d inverses (%0d singular, %0d saturated) under bursty traffic",
             n_checked, n_singular, n_saturated);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/im3_pkg.sv
sv/im3_div_lane.sv
sv/invert_matrix_3x3_unit.sv
tb/tb_invert_matrix_3x3_unit.sv
